// File: sv/at_response_line_framer_top_defines.svh
// assertion helpers shared by the line framer modules
`ifndef AT_RESPONSE_LINE_FRAMER_TOP_DEFINES_SVH
`define AT_RESPONSE_LINE_FRAMER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ALF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define ALF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ALF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define ALF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: sv/alf_pkg.sv
package alf_pkg;

	localparam int LINE_CAPACITY = 32;
	localparam int STORE_DEPTH   = LINE_CAPACITY - 1;
	localparam int LEN_W         = $clog2(LINE_CAPACITY);
	localparam int ADDR_W        = $clog2(STORE_DEPTH);
	localparam int CQ_DEPTH      = 2;
	localparam int CQ_PTR_W      = $clog2(CQ_DEPTH);
	localparam int CQ_CNT_W      = $clog2(CQ_DEPTH + 1);

	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_GT  = 8'h3E;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_NUL = 8'h00;

	typedef enum logic [1:0] {
		KIND_TAP    = 2'd0,
		KIND_CHAR   = 2'd1,
		KIND_PROMPT = 2'd2
	} kind_t;

	// one classified word handed from front to back
	typedef struct packed {
		logic [7:0]        ch;
		logic              prompt;
		logic              emit;
		logic [LEN_W-1:0]  emit_len;
		logic              store;
		logic [ADDR_W-1:0] store_addr;
	} cmd_t;

endpackage

// File: sv/alf_rx_if.sv
interface alf_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// File: sv/alf_res_if.sv
interface alf_res_if import alf_pkg::*; ();
	logic       valid;
	logic       ready;
	kind_t      kind;
	logic [7:0] data;
	logic       last;

	modport source (output valid, output kind, output data, output last, input ready);
	modport sink (input valid, input kind, input data, input last, output ready);
endinterface

// File: sv/alf_ram.sv
module alf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 31,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: sv/alf_front.sv
module alf_front import alf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  cfg_wr_en,
	input  logic  cfg_wr_data,
	alf_rx_if.sink rx,
	input  logic  q_full,
	output logic  q_push,
	output cmd_t  q_cmd
);

	`include "at_response_line_framer_top_defines.svh"

	logic             data_mode_q;
	logic [LEN_W-1:0] len_q, len_d;
	logic [LEN_W-1:0] zlen_q, zlen_d;
	logic             zero_q, zero_d;
	logic             nonblank_q, nonblank_d;
	logic [LEN_W-1:0] len_b, zlen_b;
	logic             zero_b, nonblank_b;
	logic             accept;
	logic [7:0]       c;

	assign rx.ready = !q_full;
	assign accept   = rx.valid && !q_full;
	assign c        = rx.rx_byte;
	assign q_push   = accept;

	always_comb begin
		q_cmd            = '0;
		q_cmd.ch         = c;
		q_cmd.emit_len   = zlen_q;
		len_d            = len_q;
		zlen_d           = zlen_q;
		zero_d           = zero_q;
		nonblank_d       = nonblank_q;
		len_b            = len_q;
		zlen_b           = zlen_q;
		zero_b           = zero_q;
		nonblank_b       = nonblank_q;
		if (!data_mode_q) begin
			if (c == CH_CR) begin
				// dropped
			end else if (c == CH_LF) begin
				if (len_q != '0) begin
					q_cmd.emit = nonblank_q;
					len_d      = '0;
					zlen_d     = '0;
					zero_d     = 1'b0;
					nonblank_d = 1'b0;
				end
			end else if (c == CH_GT && len_q == '0) begin
				q_cmd.prompt = 1'b1;
			end else begin
				// full store: cut the held line first
				if (len_q == LEN_W'(LINE_CAPACITY - 1)) begin
					q_cmd.emit = nonblank_q;
					len_b      = '0;
					zlen_b     = '0;
					zero_b     = 1'b0;
					nonblank_b = 1'b0;
				end
				q_cmd.store      = 1'b1;
				q_cmd.store_addr = len_b[ADDR_W-1:0];
				len_d            = len_b + 1'b1;
				zlen_d           = zlen_b;
				zero_d           = zero_b;
				nonblank_d       = nonblank_b;
				// track visible length and blankness up to the first zero byte
				if (!zero_b) begin
					if (c == CH_NUL) begin
						zero_d = 1'b1;
					end else begin
						zlen_d = zlen_b + 1'b1;
						if (!(c inside {CH_SP, CH_TAB})) begin
							nonblank_d = 1'b1;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_mode_q <= 1'b0;
			len_q       <= '0;
			zlen_q      <= '0;
			zero_q      <= 1'b0;
			nonblank_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				data_mode_q <= cfg_wr_data;
			end
			if (accept) begin
				len_q      <= len_d;
				zlen_q     <= zlen_d;
				zero_q     <= zero_d;
				nonblank_q <= nonblank_d;
			end
		end
	end

	`ALF_ASSERT_IMP(a_zlen_in_len, clk, arst_n, 1'b1, zlen_q <= len_q,
		"visible length exceeds held length")
	`ALF_ASSERT_NXT(a_lf_clears, clk, arst_n, accept && !data_mode_q && c == CH_LF,
		len_q == '0, "line feed did not clear the line")

endmodule

// File: sv/alf_cmdq.sv
module alf_cmdq import alf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output cmd_t head
);

	cmd_t                ent_q [CQ_DEPTH];
	logic [CQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CQ_CNT_W-1:0] cnt_q;
	logic                do_push, do_pop;

	function automatic logic [CQ_PTR_W-1:0] ptr_inc(input logic [CQ_PTR_W-1:0] p);
		logic [CQ_PTR_W-1:0] r;
		if (p == CQ_PTR_W'(CQ_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

	assign full       = (cnt_q == CQ_CNT_W'(CQ_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = ent_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: sv/alf_back.sv
module alf_back import alf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      head_valid,
	input  cmd_t      head,
	output logic      pop,
	alf_res_if.source res
);

	`include "at_response_line_framer_top_defines.svh"

	typedef enum logic [2:0] {
		S_TAP    = 3'b001,
		S_PROMPT = 3'b010,
		S_CH     = 3'b100
	} state_t;

	state_t            state_q, state_d;
	logic [ADDR_W-1:0] idx_q, idx_d;
	logic              out_valid_q;
	kind_t             out_kind_q, ld_kind;
	logic [7:0]        out_data_q, ld_data;
	logic              out_last_q, ld_last;
	logic              out_free, load;
	logic              rd_en, wr_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [7:0]        rd_data;
	logic              final_ch;

	assign out_free = !out_valid_q || res.ready;
	assign final_ch = (LEN_W'(idx_q) + 1'b1 == head.emit_len);

	alf_ram #(
		.WIDTH (8),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (head.store_addr),
		.wr_data (head.ch),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		load    = 1'b0;
		ld_kind = KIND_TAP;
		ld_data = head.ch;
		ld_last = 1'b0;
		pop     = 1'b0;
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		case (state_q)
			S_TAP: begin
				if (head_valid && out_free) begin
					load    = 1'b1;
					ld_last = !(head.prompt || head.emit);
					if (head.prompt) begin
						state_d = S_PROMPT;
					end else if (head.emit) begin
						rd_en   = 1'b1;
						idx_d   = '0;
						state_d = S_CH;
					end else begin
						pop   = 1'b1;
						wr_en = head.store;
					end
				end
			end
			S_PROMPT: begin
				if (out_free) begin
					load    = 1'b1;
					ld_kind = KIND_PROMPT;
					ld_data = CH_GT;
					ld_last = 1'b1;
					pop     = 1'b1;
					wr_en   = head.store;
					state_d = S_TAP;
				end
			end
			S_CH: begin
				// read data for idx_q is ready; next read overlaps the load
				if (out_free) begin
					load    = 1'b1;
					ld_kind = KIND_CHAR;
					ld_data = rd_data;
					ld_last = final_ch;
					if (final_ch) begin
						pop     = 1'b1;
						wr_en   = head.store;
						state_d = S_TAP;
					end else begin
						rd_en   = 1'b1;
						rd_addr = idx_q + 1'b1;
						idx_d   = idx_q + 1'b1;
					end
				end
			end
			default: begin
				state_d = S_TAP;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_TAP;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_kind_q <= ld_kind;
			out_data_q <= ld_data;
			out_last_q <= ld_last;
		end
	end

	assign res.valid = out_valid_q;
	assign res.kind  = out_kind_q;
	assign res.data  = out_data_q;
	assign res.last  = out_last_q;

	`ALF_ASSERT_IMP(a_idx_in_line, clk, arst_n, state_q == S_CH,
		LEN_W'(idx_q) < head.emit_len, "line index past visible length")
	`ALF_ASSERT_IMP(a_head_held, clk, arst_n, state_q != S_TAP, head_valid,
		"command left the queue mid-sequence")
	`ALF_ASSERT_IMP(a_prompt_last, clk, arst_n, out_valid_q && out_kind_q == KIND_PROMPT,
		out_last_q, "prompt word not marked last")

endmodule

// File: sv/at_response_line_framer_top.sv
// a received word is pushed into the command queue, and the back then registers
//   its tap result in the result output register
// the back sends a tap word per received word, then a prompt word or the
//   characters of an emitted line, one result word per cycle while the receiver takes them
// a two-entry command queue lets the front keep accepting while lines drain
// reset (arst_n, async low): clears mode, line length, queue and sequencer;
//   the line store memory is not cleared and needs no clearing pass
module at_response_line_framer_top import alf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	// data_mode register
	input  logic      cfg_wr_en,
	input  logic      cfg_wr_data,
	// received bytes in
	alf_rx_if.sink    rx,
	// tap, prompt and line words out
	alf_res_if.source res
);

	// front to queue
	logic q_push;
	cmd_t q_cmd;
	logic q_full;
	// queue to back
	logic q_pop;
	logic q_head_valid;
	cmd_t q_head;

	// front: takes a word, tracks the line length and blankness, classifies
	alf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.rx          (rx),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_cmd       (q_cmd)
	);

	// short queue so each side stalls on its own
	alf_cmdq u_cmdq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (q_cmd),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head       (q_head)
	);

	// back: owns the line store, sends the tap word and then any prompt or line
	// characters, then writes the new character once any pending line is read out
	alf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_head_valid),
		.head       (q_head),
		.pop        (q_pop),
		.res        (res)
	);

endmodule

// File: tb/sv/tb_at_response_line_framer_top.sv
`timescale 1ns / 100ps

module tb_at_response_line_framer_top import alf_pkg::*; ();

	// run limits
	localparam int CYCLE_LIMIT = 500000;
	localparam int SETTLE      = 8;
	localparam int HOLD_CYCLES = 400;

	// one result word as it leaves the block
	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic       last;
	} res_word_t;

	// mirrors the framer state and holds the result words still owed
	class response_tracker;
		logic [7:0]  held_chars [STORE_DEPTH];
		int unsigned held_len;
		bit          raw_mode;
		res_word_t   burst[$];
		res_word_t   pending_words[$];
		int          errors;
		int          words_checked;
		int          lines_seen;
		int          prompts_seen;

		function new();
			held_len      = 0;
			raw_mode      = 1'b0;
			errors        = 0;
			words_checked = 0;
			lines_seen    = 0;
			prompts_seen  = 0;
		endfunction

		function void add(kind_t k, logic [7:0] d);
			res_word_t w;
			w.kind = k;
			w.data = d;
			w.last = 1'b0;
			burst.push_back(w);
		endfunction

		// held line up to the first zero, dropped when empty or only blanks
		function void flush_line();
			int  n;
			bit  blank;
			n     = 0;
			blank = 1'b1;
			while (n < held_len && n < STORE_DEPTH && held_chars[n] != CH_NUL)
				n++;
			for (int i = 0; i < n; i++)
				if (held_chars[i] != CH_SP && held_chars[i] != CH_TAB)
					blank = 1'b0;
			if (n != 0 && !blank) begin
				for (int i = 0; i < n; i++)
					add(KIND_CHAR, held_chars[i]);
				lines_seen++;
			end
		endfunction

		// works out every word that one accepted byte causes
		function void take_byte(logic [7:0] c);
			res_word_t w;
			burst.delete();
			add(KIND_TAP, c);
			if (!raw_mode) begin
				if (c == CH_CR) begin
					// carriage return dropped
				end else if (c == CH_LF) begin
					if (held_len != 0) begin
						flush_line();
						held_len = 0;
					end
				end else if (c == CH_GT && held_len == 0) begin
					add(KIND_PROMPT, CH_GT);
					prompts_seen++;
				end else begin
					if (held_len + 1 >= LINE_CAPACITY) begin
						flush_line();
						held_len = 0;
					end
					if (held_len < STORE_DEPTH) begin
						held_chars[held_len] = c;
						held_len++;
					end
				end
			end
			w      = burst.pop_back();
			w.last = 1'b1;
			burst.push_back(w);
			foreach (burst[i])
				pending_words.push_back(burst[i]);
		endfunction

		function void check_word(kind_t k, logic [7:0] d, logic l);
			res_word_t w;
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected word kind %0d data %02h last %0b",
					$time, k, d, l);
				errors++;
				return;
			end
			w = pending_words.pop_front();
			words_checked++;
			if (w.kind !== k || w.data !== d || w.last !== l) begin
				$display({"%0t: mismatch expected kind %0d data %02h last %0b,",
					" got kind %0d data %02h last %0b"},
					$time, w.kind, w.data, w.last, k, d, l);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic cfg_wr_data;

	alf_rx_if  rx_ch ();
	alf_res_if res_ch ();

	response_tracker tracker;

	// idling knobs, percent per cycle
	int rx_idle_pct;
	int res_stall_pct;
	int hold_left;
	int items_sent;
	int cycle_count;

	at_response_line_framer_top DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.rx          (rx_ch),
		.res         (res_ch)
	);

	// 12 ns clock
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// watchdog against a hung handshake
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still owed", cycle_count,
				tracker.pending_words.size());
			$display("** at_response_line_framer_top: FAILED **");
			$finish;
		end
	end

	// both handshakes are observed at the rising edge only
	always @(posedge clk) begin
		if (arst_n) begin
			if (rx_ch.valid && rx_ch.ready)
				tracker.take_byte(rx_ch.rx_byte);
			if (res_ch.valid && res_ch.ready)
				tracker.check_word(res_ch.kind, res_ch.data, res_ch.last);
		end
	end

	// receiver side: random stalls plus one long hold-off on request
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				res_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				res_ch.ready <= ($urandom_range(0, 99) >= res_stall_pct);
			end
		end
	end

	// offer one byte, idle first at random, return at the accepting edge
	task automatic send_byte(logic [7:0] b);
		@(negedge clk);
		while ($urandom_range(0, 99) < rx_idle_pct) begin
			rx_ch.valid <= 1'b0;
			@(negedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		do @(posedge clk); while (!rx_ch.ready);
		items_sent++;
	endtask

	// printable text, optionally closed by lf or crlf
	task automatic send_text(int len, bit close_line);
		for (int i = 0; i < len; i++)
			send_byte(8'($urandom_range(8'h20, 8'h7E)));
		if (close_line) begin
			if ($urandom_range(0, 1))
				send_byte(CH_CR);
			send_byte(CH_LF);
		end
	endtask

	// stop offering, then wait for every owed word and let the block settle
	task automatic drain_wait();
		@(negedge clk);
		rx_ch.valid <= 1'b0;
		while (tracker.pending_words.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// mode register write, only with the block idle
	task automatic set_mode(bit m);
		drain_wait();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= m;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		tracker.raw_mode = m;
	endtask

	// mostly well formed modem traffic, some blank, zero and noise bytes
	task automatic run_traffic(int count);
		int start;
		int pick;
		start = items_sent;
		while (items_sent - start < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				send_text($urandom_range(1, 12), 1'b1);
			end else if (pick < 60) begin
				// prompt followed by a space
				send_byte(CH_GT);
				send_byte(CH_SP);
			end else if (pick < 68) begin
				// blank line of spaces and tabs
				repeat ($urandom_range(1, 5))
					send_byte($urandom_range(0, 1) ? CH_SP : CH_TAB);
				send_byte(CH_LF);
			end else if (pick < 76) begin
				// often long enough to fill the store and cut the line
				send_text($urandom_range(28, 40), 1'b1);
			end else if (pick < 84) begin
				// zero byte somewhere in the line
				send_text($urandom_range(0, 4), 1'b0);
				send_byte(CH_NUL);
				send_text($urandom_range(0, 4), 1'b1);
			end else begin
				repeat ($urandom_range(1, 4))
					send_byte(8'($urandom_range(0, 255)));
			end
		end
	endtask

	initial begin
		logic [7:0] directed_bytes[$];

		tracker       = new();
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = 1'b0;
		rx_ch.valid   = 1'b0;
		rx_ch.rx_byte = 8'h00;
		rx_idle_pct   = 0;
		res_stall_pct = 0;
		hold_left     = 0;
		items_sent    = 0;

		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		set_mode(1'b0);

		// directed: prompt, '>' mid line, top bit values, cr, lf on empty store,
		// blank line, line starting with zero, zero cutting a line
		directed_bytes = '{CH_GT, 8'h41, CH_GT, 8'hFF, 8'h80, CH_CR, CH_LF, CH_LF,
			CH_SP, CH_TAB, CH_SP, CH_CR, CH_LF,
			CH_NUL, 8'h42, CH_LF,
			8'h43, CH_NUL, 8'h44, CH_LF,
			8'h7F, 8'h01, CH_GT, CH_LF};
		foreach (directed_bytes[i])
			send_byte(directed_bytes[i]);

		// line mode, no idling, opens with a line longer than the store
		send_text(35, 1'b1);
		run_traffic(12);
		// partial line left held across the mode change
		send_text(3, 1'b0);

		// pass-through with an idle sender
		set_mode(1'b1);
		rx_idle_pct   = 60;
		res_stall_pct = 0;
		run_traffic(8);

		// line mode resumes with the held partial line, receiver stalling
		set_mode(1'b0);
		rx_idle_pct   = 0;
		res_stall_pct = 60;
		run_traffic(16);

		// both sides idling a little
		rx_idle_pct   = 14;
		res_stall_pct = 14;
		run_traffic(12);

		set_mode(1'b1);
		run_traffic(6);

		// receiver holds off while the sender keeps pushing long lines
		set_mode(1'b0);
		rx_idle_pct   = 0;
		res_stall_pct = 0;
		@(posedge clk);
		hold_left = HOLD_CYCLES;
		send_text(33, 1'b1);
		run_traffic(10);

		drain_wait();

		$display("sent %0d bytes in line and pass-through modes, checked %0d result words",
			items_sent, tracker.words_checked);
		$display("%0d lines framed, %0d prompts, %0d errors, with one long output hold-off",
			tracker.lines_seen, tracker.prompts_seen, tracker.errors);
		if (tracker.errors == 0 && tracker.pending_words.size() == 0) begin
			$display("** at_response_line_framer_top: PASSED **");
		end else begin
			$display("** at_response_line_framer_top: FAILED **");
		end
		$finish;
	end

endmodule
